FILE: rtl/sws_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sws_pkg
// Shared types and constants of the sliding window statistics block.
// ----------------------------------------------------------------------------
package sws_pkg;

    localparam int SAMPLE_W = 16;
    localparam int COUNT_W  = 7;
    localparam int SUM_W    = 23;
    localparam int SQSUM_W  = 37;
    localparam int AVG_W    = 24;
    localparam int SD_W     = 24;
    localparam int OP_W     = 2;

    localparam logic [OP_W-1:0] OP_ADD    = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR  = 2'd1;
    localparam logic [OP_W-1:0] OP_RECENT = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_UPDATE,
        S_STATS,
        S_WAIT,
        S_STATUS,
        S_FETCH,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic signed [AVG_W-1:0] avg;
        logic        [SD_W-1:0]  sd;
    } t_stats;

endpackage
`default_nettype wire

FILE: rtl/sliding_window_statistics.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_statistics
// Windowed mean and standard deviation with minimum and maximum since the last clear.
// ----------------------------------------------------------------------------
// Every request runs the 59-step variance division followed by the 24-step
// square root before its result. A recent read then gives its samples one at a
// time, each fetched from the ring read port before it is emitted. One request
// is handled at a time: a new one is taken only after the last result has been
// loaded into the output register. Synchronous active-low reset clears all
// counters and statistics; ring contents stay undefined.
module sliding_window_statistics
    import sws_pkg::*;
#(
    parameter int WINDOW_DEPTH = 64
) (
    input  wire           i_clk,
    input  wire           i_rst_n,
    input  wire           i_s_tvalid,
    output logic          o_s_tready,
    input  wire  [23:0]   i_s_tdata,   // sample, recent_count, zero pad
    input  wire  [1:0]    i_s_tuser,   // op
    output logic          o_m_tvalid,
    input  wire           i_m_tready,
    output logic [103:0]  o_m_tdata,   // average_q8, minimum, maximum, stddev_q8,
                                       // sample_count, recent_value, zero pad
    output logic [0:0]    o_m_tuser,   // value_valid
    output logic          o_m_tlast,
    input  wire           i_cfg_valid,
    output logic          o_cfg_ready,
    input  wire  [6:0]    i_cfg_data
);

    localparam int AW = $clog2(WINDOW_DEPTH);
    localparam int IW = AW + 2;

    t_state                     r_state, n_state;
    logic [AW-1:0]              r_wp;
    logic [COUNT_W-1:0]         r_fill;
    logic signed [SUM_W-1:0]    r_sum;
    logic [SQSUM_W-1:0]         r_sqsum;
    logic signed [SAMPLE_W-1:0] r_lo, r_hi;
    logic                       r_any;
    logic [COUNT_W-1:0]         r_limit;
    logic [COUNT_W-1:0]         r_back;
    logic signed [SAMPLE_W-1:0] r_sample;
    logic [31:0]                r_sqx;
    logic                       r_ovalid;
    logic [103:0]               r_odata;
    logic                       r_ovld_flag;
    logic                       r_olast;

    logic                       in_acc;
    logic                       out_free;
    logic                       ready;
    logic                       rd_en;
    logic                       wr_en;
    logic                       st_start;
    logic                       load_status;
    logic                       load_value;
    logic [COUNT_W-1:0]         lim;
    logic                       evict;
    logic [COUNT_W-1:0]         back_sel;
    logic [IW-1:0]              idx_sum;
    logic [AW-1:0]              rd_addr;
    logic signed [SAMPLE_W-1:0] rd_data;
    logic [31:0]                old_sq;
    logic [COUNT_W-1:0]         want, k_run;
    logic signed [SAMPLE_W-1:0] in_sample;
    t_stats                     stats;
    logic                       st_done;

    assign in_sample = i_s_tdata[15:0];
    assign want      = i_s_tdata[22:16];
    assign in_acc    = i_s_tvalid && ready;
    assign out_free  = !r_ovalid || i_m_tready;
    assign k_run     = (want < r_fill) ? want : r_fill;

    assign lim = (r_limit == '0) ? COUNT_W'(1) :
                 (r_limit > COUNT_W'(WINDOW_DEPTH)) ? COUNT_W'(WINDOW_DEPTH) : r_limit;
    assign evict = (r_fill >= lim) && (r_fill != '0);

    // Oldest entry is fill places behind the write position, modulo the depth.
    assign back_sel = (r_state == S_READ) ?
                      ((r_fill == COUNT_W'(WINDOW_DEPTH)) ? '0 : r_fill) : r_back;
    assign idx_sum  = IW'(r_wp) + IW'(WINDOW_DEPTH) - IW'(back_sel);
    assign rd_addr  = (idx_sum >= IW'(WINDOW_DEPTH)) ?
                      AW'(idx_sum - IW'(WINDOW_DEPTH)) : AW'(idx_sum);
    assign old_sq   = 32'(rd_data * rd_data);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_state = (i_s_tuser == OP_ADD) ? S_READ : S_STATS;
                end
            end
            S_READ:   n_state = S_UPDATE;
            S_UPDATE: n_state = S_STATS;
            S_STATS:  n_state = S_WAIT;
            S_WAIT: begin
                if (st_done) begin
                    n_state = (r_back != '0) ? S_FETCH : S_STATUS;
                end
            end
            S_STATUS: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            S_FETCH: n_state = S_EMIT;
            S_EMIT: begin
                if (out_free) begin
                    n_state = (r_back == COUNT_W'(1)) ? S_IDLE : S_FETCH;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        ready       = 1'b0;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        st_start    = 1'b0;
        load_status = 1'b0;
        load_value  = 1'b0;
        unique case (r_state)
            S_IDLE:   ready = 1'b1;
            S_READ:   rd_en = 1'b1;
            S_UPDATE: wr_en = 1'b1;
            S_STATS:  st_start = 1'b1;
            S_WAIT:   ;
            S_STATUS: load_status = out_free;
            S_FETCH:  rd_en = 1'b1;
            S_EMIT:   load_value = out_free;
            default:  ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_wp     <= '0;
            r_fill   <= '0;
            r_sum    <= '0;
            r_sqsum  <= '0;
            r_lo     <= '0;
            r_hi     <= '0;
            r_any    <= 1'b0;
            r_limit  <= COUNT_W'(64);
            r_back   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) begin
                r_limit <= i_cfg_data;
            end
            if (in_acc) begin
                r_back <= (i_s_tuser == OP_RECENT) ? k_run : '0;
                if (i_s_tuser == OP_CLEAR) begin
                    r_wp    <= '0;
                    r_fill  <= '0;
                    r_sum   <= '0;
                    r_sqsum <= '0;
                    r_lo    <= '0;
                    r_hi    <= '0;
                    r_any   <= 1'b0;
                end
            end
            if (wr_en) begin
                r_wp <= (r_wp == AW'(WINDOW_DEPTH - 1)) ? '0 : r_wp + AW'(1);
                if (evict) begin
                    r_sum   <= r_sum - SUM_W'(rd_data) + SUM_W'(r_sample);
                    r_sqsum <= r_sqsum - SQSUM_W'(old_sq) + SQSUM_W'(r_sqx);
                end else begin
                    r_fill  <= r_fill + COUNT_W'(1);
                    r_sum   <= r_sum + SUM_W'(r_sample);
                    r_sqsum <= r_sqsum + SQSUM_W'(r_sqx);
                end
                r_any <= 1'b1;
                if (!r_any || r_sample < r_lo) begin
                    r_lo <= r_sample;
                end
                if (!r_any || r_sample > r_hi) begin
                    r_hi <= r_sample;
                end
            end
            if (load_value) begin
                r_back <= r_back - COUNT_W'(1);
            end
            if (load_status || load_value) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_sample <= in_sample;
        end
        if (r_state == S_READ) begin
            r_sqx <= 32'(r_sample * r_sample);
        end
        if (load_status || load_value) begin
            r_odata <= {1'b0,
                        load_value ? rd_data : SAMPLE_W'(0),
                        r_fill, stats.sd, r_hi, r_lo, stats.avg};
            r_ovld_flag <= load_value;
            r_olast     <= load_status || (r_back == COUNT_W'(1));
        end
    end

    sws_ring #(
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_wp),
        .i_wr_data (r_sample)
    );

    sws_stats u_stats (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (st_start),
        .i_count (r_fill),
        .i_sum   (r_sum),
        .i_sqsum (r_sqsum),
        .o_stats (stats),
        .o_done  (st_done)
    );

    assign o_s_tready  = ready;
    assign o_cfg_ready = 1'b1;
    assign o_m_tvalid  = r_ovalid;
    assign o_m_tdata   = r_odata;
    assign o_m_tuser   = r_ovld_flag;
    assign o_m_tlast   = r_olast;

endmodule
`default_nettype wire

FILE: rtl/sws_ring.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sws_ring
// Sample ring memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module sws_ring
    import sws_pkg::*;
#(
    parameter int DEPTH = 64
) (
    input  wire                          i_clk,
    input  wire                          i_rd_en,
    input  wire  [$clog2(DEPTH)-1:0]     i_rd_addr,
    output logic signed [SAMPLE_W-1:0]   o_rd_data,
    input  wire                          i_wr_en,
    input  wire  [$clog2(DEPTH)-1:0]     i_wr_addr,
    input  wire  signed [SAMPLE_W-1:0]   i_wr_data
);

    logic signed [SAMPLE_W-1:0] r_mem [DEPTH];
    logic signed [SAMPLE_W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

FILE: rtl/sws_div.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sws_div
// Restoring divider that produces one quotient bit per cycle.
// ----------------------------------------------------------------------------
module sws_div #(
    parameter int NUM_W = 30,
    parameter int DEN_W = 7
) (
    input  wire              i_clk,
    input  wire              i_rst_n,
    input  wire              i_start,
    input  wire  [NUM_W-1:0] i_num,
    input  wire  [DEN_W-1:0] i_den,
    output logic [NUM_W-1:0] o_quot,
    output logic [DEN_W-1:0] o_rem,
    output logic             o_done
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             r_busy, n_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [NUM_W-1:0] r_num;
    logic [NUM_W-1:0] r_quot;
    logic [DEN_W-1:0] r_rem;
    logic [DEN_W-1:0] r_den;
    logic [DEN_W:0]   trial;
    logic             q_bit;

    assign trial = {r_rem, r_num[NUM_W-1]};
    assign q_bit = (trial >= {1'b0, r_den});
    assign n_busy = r_busy && (r_cnt != CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(NUM_W);
            end else if (r_busy) begin
                r_busy <= n_busy;
                r_done <= !n_busy;
                r_cnt  <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num  <= {r_num[NUM_W-2:0], 1'b0};
            r_quot <= {r_quot[NUM_W-2:0], q_bit};
            if (q_bit) begin
                r_rem <= DEN_W'(trial - {1'b0, r_den});
            end else begin
                r_rem <= trial[DEN_W-1:0];
            end
        end
    end

    assign o_quot = r_quot;
    assign o_rem  = r_rem;
    assign o_done = r_done;

endmodule
`default_nettype wire

FILE: rtl/sws_sqrt.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sws_sqrt
// Integer square root that settles one result bit per cycle.
// ----------------------------------------------------------------------------
module sws_sqrt #(
    parameter int X_W = 48
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_start,
    input  wire  [X_W-1:0]     i_x,
    output logic [X_W/2-1:0]   o_root,
    output logic               o_done
);

    localparam int STEPS = X_W / 2;
    localparam int CNT_W = $clog2(STEPS + 1);

    logic             r_busy, n_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [X_W-1:0]   r_x;
    logic [X_W-1:0]   r_res;
    logic [X_W-1:0]   r_bit;
    logic [X_W-1:0]   trial;

    assign trial  = r_res + r_bit;
    assign n_busy = r_busy && (r_cnt != CNT_W'(1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CNT_W'(STEPS);
            end else if (r_busy) begin
                r_busy <= n_busy;
                r_done <= !n_busy;
                r_cnt  <= r_cnt - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x   <= i_x;
            r_res <= '0;
            r_bit <= X_W'(1) << (X_W - 2);
        end else if (r_busy) begin
            if (r_x >= trial) begin
                r_x   <= r_x - trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
            r_bit <= r_bit >> 2;
        end
    end

    assign o_root = r_res[X_W/2-1:0];
    assign o_done = r_done;

endmodule
`default_nettype wire

FILE: rtl/sws_stats.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sws_stats
// Mean and population standard deviation in Q8 from count, sum and square sum.
// ----------------------------------------------------------------------------
module sws_stats
    import sws_pkg::*;
(
    input  wire                        i_clk,
    input  wire                        i_rst_n,
    input  wire                        i_start,
    input  wire  [COUNT_W-1:0]         i_count,
    input  wire  signed [SUM_W-1:0]    i_sum,
    input  wire  [SQSUM_W-1:0]         i_sqsum,
    output t_stats                     o_stats,
    output logic                       o_done
);

    localparam int ABS_W  = SUM_W - 1;
    localparam int PROD_W = 2 * ABS_W;
    localparam int NN_W   = 13;
    localparam int ANUM_W = ABS_W + 8;
    localparam int VNUM_W = PROD_W - 1 + 16;
    localparam int ROOT_X = 48;

    logic                r_v1;
    logic [COUNT_W-1:0]  r_n;
    logic                r_neg;
    logic [PROD_W-1:0]   r_prod_a;
    logic [PROD_W-1:0]   r_prod_b;
    logic [NN_W-1:0]     r_nn;
    logic [ANUM_W-1:0]   r_anum;
    logic [SUM_W-1:0]    sum_abs_w;
    logic [ABS_W-1:0]    sum_abs;
    logic [PROD_W-1:0]   diff;
    logic [ANUM_W-1:0]   avg_q;
    logic [COUNT_W-1:0]  avg_r;
    logic                avg_done;
    logic [VNUM_W-1:0]   var_q;
    logic [NN_W-1:0]     var_r;
    logic                var_done;
    logic [ROOT_X/2-1:0] root;
    logic                root_done;
    logic [ANUM_W-1:0]   avg_mag;
    logic [ANUM_W-1:0]   avg_val;

    assign sum_abs_w = i_sum[SUM_W-1] ? SUM_W'(-i_sum) : i_sum;
    assign sum_abs   = sum_abs_w[ABS_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_n      <= i_count;
            r_neg    <= i_sum[SUM_W-1];
            r_prod_a <= PROD_W'(i_count) * PROD_W'(i_sqsum);
            r_prod_b <= PROD_W'(sum_abs) * PROD_W'(sum_abs);
            r_nn     <= NN_W'(i_count) * NN_W'(i_count);
            r_anum   <= {sum_abs, 8'b0};
        end
    end

    assign diff = (r_prod_a >= r_prod_b) ? (r_prod_a - r_prod_b) : '0;

    sws_div #(
        .NUM_W (ANUM_W),
        .DEN_W (COUNT_W)
    ) u_avg_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_v1),
        .i_num   (r_anum),
        .i_den   (r_n),
        .o_quot  (avg_q),
        .o_rem   (avg_r),
        .o_done  (avg_done)
    );

    sws_div #(
        .NUM_W (VNUM_W),
        .DEN_W (NN_W)
    ) u_var_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_v1),
        .i_num   ({diff[PROD_W-2:0], 16'b0}),
        .i_den   (r_nn),
        .o_quot  (var_q),
        .o_rem   (var_r),
        .o_done  (var_done)
    );

    sws_sqrt #(
        .X_W (ROOT_X)
    ) u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (var_done),
        .i_x     (var_q[ROOT_X-1:0]),
        .o_root  (root),
        .o_done  (root_done)
    );

    // The mean is floored, so a negative quotient with a remainder steps down by one.
    assign avg_mag = avg_q + ANUM_W'(r_neg && (avg_r != '0) && (var_r == var_r));
    assign avg_val = r_neg ? ANUM_W'(-avg_mag) : avg_mag;

    assign o_stats.avg = (r_n == '0) ? '0 : AVG_W'(avg_val);
    assign o_stats.sd  = (r_n < COUNT_W'(2)) ? '0 : SD_W'(root);
    assign o_done      = root_done && !avg_done;

endmodule
`default_nettype wire

FILE: tb/tb_sliding_window_statistics.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sliding_window_statistics
// Drives add, clear, recent and unused requests into the statistics block,
// computes the expected mean, deviation, extremes and recent samples in a
// local copy of the window, and compares every result field by field while
// both stream sides stall at random outside a calm random-test stretch.
// ----------------------------------------------------------------------------
module tb_sliding_window_statistics;
    import sws_pkg::*;

    localparam int DEPTH = 64;
    localparam int SETTLE = 120;
    localparam int CYCLE_LIMIT = 2000000;
    localparam int EXP_DEPTH = 256;

    typedef struct {
        logic signed [AVG_W-1:0]    avg;
        logic signed [SAMPLE_W-1:0] lo;
        logic signed [SAMPLE_W-1:0] hi;
        logic [SD_W-1:0]            sd;
        logic [COUNT_W-1:0]         cnt;
        logic signed [SAMPLE_W-1:0] val;
        logic                       vld;
        logic                       last;
    } t_stat_result;

    logic           i_clk = 1'b0;
    logic           i_rst_n = 1'b0;
    logic           s_valid = 1'b0;
    logic [23:0]    s_data = '0;
    logic [1:0]     s_user = '0;
    logic           m_ready = 1'b0;
    logic           cfg_valid = 1'b0;
    logic [6:0]     cfg_data = '0;
    wire            s_ready;
    wire            m_valid;
    wire  [103:0]   m_data;
    wire  [0:0]     m_user;
    wire            m_last;
    wire            cfg_ready;

    sliding_window_statistics u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (s_valid),
        .o_s_tready  (s_ready),
        .i_s_tdata   (s_data),
        .i_s_tuser   (s_user),
        .o_m_tvalid  (m_valid),
        .i_m_tready  (m_ready),
        .o_m_tdata   (m_data),
        .o_m_tuser   (m_user),
        .o_m_tlast   (m_last),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_data  (cfg_data)
    );

    always #6 i_clk = ~i_clk;

    // Window model.
    logic signed [SAMPLE_W-1:0] ring [DEPTH];
    logic [5:0]                 wr_pos;
    int                         fill;
    longint                     win_sum;
    longint                     win_sq;
    logic signed [SAMPLE_W-1:0] lo_seen;
    logic signed [SAMPLE_W-1:0] hi_seen;
    logic                       seen;
    logic [6:0]                 win_limit;

    t_stat_result exp_fifo [EXP_DEPTH];
    int exp_wr = 0;
    int exp_rd = 0;
    int errors = 0;
    int cycles = 0;
    bit calm = 1'b0;

    task automatic report(input string msg);
        $display("mismatch at cycle %0d: %s", cycles, msg);
        errors++;
    endtask

    function automatic void exp_put(input t_stat_result r);
        exp_fifo[exp_wr % EXP_DEPTH] = r;
        exp_wr++;
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned x);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= res + b) begin
                x = x - (res + b);
                res = (res >> 1) + b;
            end else begin
                res >>= 1;
            end
            b >>= 2;
        end
        return res;
    endfunction

    function automatic void push_stats(input logic signed [SAMPLE_W-1:0] val,
                                       input logic vld, input logic last);
        t_stat_result r;
        longint num, q, d, n;
        num = 0;
        q = 0;
        n = fill;
        r.sd = '0;
        if (n > 0) begin
            num = win_sum * 256;
            q = num / n;
            if ((num % n) != 0 && num < 0) q = q - 1;
        end
        r.avg = q[AVG_W-1:0];
        if (n >= 2) begin
            d = n * win_sq - win_sum * win_sum;
            if (d < 0) d = 0;
            r.sd = SD_W'(int_sqrt((longint'(d) * 65536) / (n * n)));
        end
        r.lo = seen ? lo_seen : '0;
        r.hi = seen ? hi_seen : '0;
        r.cnt = fill[COUNT_W-1:0];
        r.val = val;
        r.vld = vld;
        r.last = last;
        exp_put(r);
    endfunction

    function automatic void predict_request(input logic [1:0] op,
                                            input logic signed [SAMPLE_W-1:0] x,
                                            input logic [6:0] want);
        int lim, k;
        logic [5:0] idx;
        lim = (win_limit == 0) ? 1 : (win_limit > DEPTH) ? DEPTH : win_limit;
        if (op == OP_ADD) begin
            if (fill >= lim && fill > 0) begin
                idx = wr_pos - 6'(fill);
                win_sum -= ring[idx];
                win_sq -= longint'(ring[idx]) * ring[idx];
            end else begin
                fill++;
            end
            ring[wr_pos] = x;
            wr_pos++;
            win_sum += x;
            win_sq += longint'(x) * x;
            if (!seen) begin
                lo_seen = x;
                hi_seen = x;
                seen = 1'b1;
            end else begin
                if (x < lo_seen) lo_seen = x;
                if (x > hi_seen) hi_seen = x;
            end
            push_stats('0, 1'b0, 1'b1);
        end else if (op == OP_CLEAR) begin
            wr_pos = '0;
            fill = 0;
            win_sum = 0;
            win_sq = 0;
            lo_seen = '0;
            hi_seen = '0;
            seen = 1'b0;
            push_stats('0, 1'b0, 1'b1);
        end else if (op == OP_RECENT) begin
            k = (want < fill) ? want : fill;
            if (k == 0) push_stats('0, 1'b0, 1'b1);
            for (int i = 0; i < k; i++) begin
                idx = wr_pos - 6'(k - i);
                push_stats(ring[idx], 1'b1, (i + 1 == k));
            end
        end else begin
            push_stats('0, 1'b0, 1'b1);
        end
    endfunction

    // Called at a falling edge; returns at a falling edge with valid held.
    task automatic send_request(input logic [1:0] op, input logic [15:0] x,
                                input logic [6:0] want);
        if (!calm && $urandom_range(99) < 12) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        s_valid <= 1'b1;
        s_user <= op;
        s_data <= {1'b0, want, x};
        @(posedge i_clk);
        while (!s_ready) @(posedge i_clk);
        predict_request(op, x, want);
        @(negedge i_clk);
    endtask

    task automatic drain();
        s_valid <= 1'b0;
        while (exp_wr != exp_rd) @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic set_limit(input logic [6:0] v);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        win_limit = v;
        @(negedge i_clk);
        cfg_valid <= 1'b0;
    endtask

    always @(negedge i_clk) begin
        if (!i_rst_n) m_ready <= 1'b0;
        else m_ready <= calm ? 1'b1 : ($urandom_range(99) >= 12);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        t_stat_result e;
        if (i_rst_n && m_valid && m_ready) begin
            if (exp_wr == exp_rd) begin
                report("result with nothing expected");
            end else begin
                e = exp_fifo[exp_rd % EXP_DEPTH];
                exp_rd++;
                if (m_data[23:0] !== e.avg) report($sformatf("average %h exp %h",
                    m_data[23:0], e.avg));
                if (m_data[39:24] !== e.lo) report($sformatf("minimum %h exp %h",
                    m_data[39:24], e.lo));
                if (m_data[55:40] !== e.hi) report($sformatf("maximum %h exp %h",
                    m_data[55:40], e.hi));
                if (m_data[79:56] !== e.sd) report($sformatf("stddev %h exp %h",
                    m_data[79:56], e.sd));
                if (m_data[86:80] !== e.cnt) report($sformatf("count %0d exp %0d",
                    m_data[86:80], e.cnt));
                if (m_data[102:87] !== e.val) report($sformatf("recent %h exp %h",
                    m_data[102:87], e.val));
                if (m_user[0] !== e.vld) report($sformatf("valid %b exp %b",
                    m_user[0], e.vld));
                if (m_last !== e.last) report($sformatf("last %b exp %b",
                    m_last, e.last));
            end
        end
    end

    task automatic test_directed();
        send_request(OP_RECENT, 16'h0000, 7'd5);
        send_request(OP_ADD, 16'h7FFF, 7'd0);
        send_request(OP_ADD, 16'h7FFF, 7'd127);
        send_request(OP_ADD, 16'h8000, 7'd0);
        send_request(OP_ADD, 16'h0000, 7'd0);
        send_request(OP_ADD, 16'hFFFF, 7'd64);
        send_request(OP_RECENT, 16'hFFFF, 7'd0);
        send_request(OP_RECENT, 16'h0000, 7'd3);
        send_request(OP_RECENT, 16'h0000, 7'd127);
        send_request(2'd3, 16'hFFFF, 7'd127);
        send_request(OP_CLEAR, 16'h1234, 7'd10);
        send_request(OP_RECENT, 16'h0000, 7'd64);
        send_request(OP_ADD, 16'h8000, 7'd0);
        send_request(OP_ADD, 16'h8000, 7'd0);
        send_request(OP_RECENT, 16'h0000, 7'd2);
        send_request(OP_CLEAR, 16'h0000, 7'd0);
    endtask

    task automatic test_limits();
        set_limit(7'd1);
        repeat (3) send_request(OP_ADD, 16'($urandom_range(0, 65535)), 7'd0);
        send_request(OP_RECENT, 16'h0000, 7'd4);
        set_limit(7'd0);
        repeat (2) send_request(OP_ADD, 16'($urandom_range(0, 65535)), 7'd0);
        set_limit(7'd127);
        repeat (70) send_request(OP_ADD, 16'($urandom_range(0, 65535)), 7'd0);
        send_request(OP_RECENT, 16'h0000, 7'd64);
        // Lowering the limit below the fill keeps the fill where it is.
        set_limit(7'd3);
        repeat (3) send_request(OP_ADD, 16'($urandom_range(0, 65535)), 7'd0);
        send_request(OP_RECENT, 16'h0000, 7'd100);
        set_limit(7'd100);
        send_request(OP_CLEAR, 16'h0000, 7'd0);
        set_limit(7'd64);
    endtask

    task automatic test_random();
        int r;
        logic [15:0] x;
        for (int i = 0; i < 262; i++) begin
            if (i == 90) set_limit(7'($urandom_range(1, 16)));
            if (i == 180) set_limit(7'($urandom_range(0, 127)));
            if (i == 230) set_limit(7'd64);
            calm = (i >= 120 && i < 170);
            if (i == 220) drain();
            r = $urandom_range(99);
            x = ($urandom_range(3) == 0) ? 16'($urandom_range(0, 15) - 8)
                                         : 16'($urandom_range(0, 65535));
            if (r < 70) send_request(OP_ADD, x, 7'($urandom_range(0, 127)));
            else if (r < 90) send_request(OP_RECENT, x, ($urandom_range(3) == 0) ?
                7'($urandom_range(0, 127)) : 7'($urandom_range(0, 12)));
            else if (r < 95) send_request(2'd3, x, 7'($urandom_range(0, 127)));
            else send_request(OP_CLEAR, x, 7'($urandom_range(0, 127)));
        end
        calm = 1'b0;
    endtask

    initial begin
        wr_pos = '0;
        fill = 0;
        win_sum = 0;
        win_sq = 0;
        lo_seen = '0;
        hi_seen = '0;
        seen = 1'b0;
        win_limit = 7'd64;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);
        test_directed();
        test_limits();
        test_random();
        drain();
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
